// File: rtl/bce_pkg.sv
// Shared types and constants of the four-band crossover equalizer.
// Used by the divider, the controller, the datapath and the top level.
`default_nettype none
package bce_pkg;

   // Working widths
   localparam int VW         = 36;   // stage input, band and curve values
   localparam int SUM_W      = 48;   // window sum
   localparam int PT_W       = 32;   // curve points
   localparam int XF         = 24;   // fraction bits of position and weights
   localparam int W_W        = 25;   // position and weights, up to 1.0
   localparam int F_W        = 24;   // newest-point factor
   localparam int GAIN_W     = 18;
   localparam int PER_W      = 20;
   localparam int CNT_W      = 21;   // count + 1
   localparam int ACC_W      = 64;
   localparam int MUL_AW     = 36;
   localparam int MUL_BW     = 26;
   localparam int PROD_W     = MUL_AW + MUL_BW;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Divider
   localparam int DIV_NW = 53;
   localparam int DIV_DW = 30;
   localparam int DIV_LW = 6;
   localparam logic [DIV_LW-1:0] LEN_AVG = 6'd48;
   localparam logic [DIV_LW-1:0] LEN_F   = 6'd53;
   localparam logic [DIV_LW-1:0] LEN_X   = 6'd45;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGHMID_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOWMID_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASS_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UPPER_PERIOD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MIDDLE_PERIOD = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LOWER_PERIOD  = 3'd6;

   localparam logic [GAIN_W-1:0] GAIN_RESET  = 18'd65536;
   localparam logic [PER_W-1:0]  UPPER_RESET = 20'd1;
   localparam logic [PER_W-1:0]  MID_RESET   = 20'd4;
   localparam logic [PER_W-1:0]  LOWER_RESET = 20'd20;

   // Crossover stage position within a pass, and gain select
   localparam logic [1:0] K_UPPER  = 2'd0;
   localparam logic [1:0] K_MIDDLE = 2'd1;
   localparam logic [1:0] K_LOWER  = 2'd2;
   localparam logic [1:0] G_HIGH    = 2'd0;
   localparam logic [1:0] G_HIGHMID = 2'd1;
   localparam logic [1:0] G_LOWMID  = 2'd2;
   localparam logic [1:0] G_BASS    = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE, OP_TAKE, OP_LOAD, OP_NEWPT, OP_FIN, OP_MIX_FIN, OP_OUT
   } op_type;

   typedef enum logic [1:0] {DIV_AVG, DIV_F, DIV_X} div_sel_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_AF, MUL_UU, MUL_UX, MUL_XX, MUL_OD, MUL_MC, MUL_NB, MUL_BG
   } mul_sel_type;

   typedef enum logic [1:0] {ACC_KEEP, ACC_LOAD, ACC_ADD} acc_type;

   typedef enum logic [1:0] {LAT_NONE, LAT_WD, LAT_WC, LAT_WB} lat_type;

   typedef struct packed {
      op_type      op;
      logic        div_start;
      div_sel_type div_sel;
      mul_sel_type mul_sel;
      acc_type     acc;
      lat_type     lat;
      logic [1:0]  band;
      logic [1:0]  gsel;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/bce_div.sv
// Restoring divider, one quotient bit per cycle, variable dividend length.
// Uses bce_pkg for widths.
`default_nettype none
module bce_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [bce_pkg::DIV_NW-1:0]  dividend,
   input  wire logic [bce_pkg::DIV_DW-1:0]  divisor,
   input  wire logic [bce_pkg::DIV_LW-1:0]  len,
   output logic                             done,
   output logic [bce_pkg::DIV_NW-1:0]       quotient
);
   localparam int NW = bce_pkg::DIV_NW;
   localparam int DW = bce_pkg::DIV_DW;
   localparam int LW = bce_pkg::DIV_LW;

   logic          busy_ff, done_ff;
   logic [LW-1:0] cnt_ff;
   logic [NW-1:0] dq_ff;
   logic [DW-1:0] rem_ff, den_ff;
   logic [DW:0]   rem_sh;
   logic          ge;
   logic [DW-1:0] rem_in;

   // one trial subtraction
   always_comb begin
      rem_sh = {rem_ff, dq_ff[NW-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      rem_in = ge ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= len;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == LW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // dividend left-aligned, quotient bits shift in from the bottom
   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend << (LW'(NW) - len);
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         dq_ff  <= {dq_ff[NW-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;
endmodule
`default_nettype wire

// File: rtl/bce_ctrl.sv
// Sequencer of the equalizer: walks stages and passes, issues datapath commands.
// Uses bce_pkg for command and status types.
`default_nettype none
module bce_ctrl #(
   parameter int STAGES = 9,
   parameter int SIDX_W = 4
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [SIDX_W-1:0]        stage_idx,
   output bce_pkg::cmd_type         cmd,
   input  wire bce_pkg::status_type status
);
   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_BRANCH, S_AVG_GO, S_AVG_WAIT, S_F_GO, S_F_WAIT,
      S_NP_MUL, S_NP_SET, S_XQ_GO, S_XQ_WAIT, S_W_UU, S_W_UX, S_W_XX,
      S_A_OD, S_A_MC, S_A_NB, S_FIN, S_MIX0, S_MIX1, S_MIX2, S_MIX3,
      S_MIX_FIN, S_OUT
   } state_type;

   state_type         state_ff;
   logic [SIDX_W-1:0] stage_ff;
   logic [1:0]        k_ff;
   logic              rsp_tvalid_ff;
   logic              out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign stage_idx  = stage_ff;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // command decode
   always_comb begin
      cmd           = '0;
      cmd.op        = bce_pkg::OP_NONE;
      cmd.div_sel   = bce_pkg::DIV_AVG;
      cmd.mul_sel   = bce_pkg::MUL_NONE;
      cmd.acc       = bce_pkg::ACC_KEEP;
      cmd.lat       = bce_pkg::LAT_NONE;
      cmd.band      = k_ff;
      cmd.gsel      = bce_pkg::G_HIGH;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) cmd.op = bce_pkg::OP_TAKE;
         S_LOAD:     cmd.op = bce_pkg::OP_LOAD;
         S_AVG_GO:   begin cmd.div_start = 1'b1; cmd.div_sel = bce_pkg::DIV_AVG; end
         S_AVG_WAIT: cmd.div_sel = bce_pkg::DIV_AVG;
         S_F_GO:     begin cmd.div_start = 1'b1; cmd.div_sel = bce_pkg::DIV_F; end
         S_F_WAIT:   cmd.div_sel = bce_pkg::DIV_F;
         S_NP_MUL:   cmd.mul_sel = bce_pkg::MUL_AF;
         S_NP_SET:   cmd.op = bce_pkg::OP_NEWPT;
         S_XQ_GO:    begin cmd.div_start = 1'b1; cmd.div_sel = bce_pkg::DIV_X; end
         S_XQ_WAIT:  cmd.div_sel = bce_pkg::DIV_X;
         S_W_UU:     cmd.mul_sel = bce_pkg::MUL_UU;
         S_W_UX:     begin cmd.mul_sel = bce_pkg::MUL_UX; cmd.lat = bce_pkg::LAT_WD; end
         S_W_XX:     begin cmd.mul_sel = bce_pkg::MUL_XX; cmd.lat = bce_pkg::LAT_WC; end
         S_A_OD:     begin cmd.mul_sel = bce_pkg::MUL_OD; cmd.lat = bce_pkg::LAT_WB; end
         S_A_MC:     begin cmd.mul_sel = bce_pkg::MUL_MC; cmd.acc = bce_pkg::ACC_LOAD; end
         S_A_NB:     begin cmd.mul_sel = bce_pkg::MUL_NB; cmd.acc = bce_pkg::ACC_ADD; end
         S_FIN:      cmd.op = bce_pkg::OP_FIN;
         S_MIX0:     begin cmd.mul_sel = bce_pkg::MUL_BG; cmd.gsel = bce_pkg::G_HIGH; end
         S_MIX1: begin
            cmd.mul_sel = bce_pkg::MUL_BG; cmd.gsel = bce_pkg::G_HIGHMID;
            cmd.acc = bce_pkg::ACC_LOAD;
         end
         S_MIX2: begin
            cmd.mul_sel = bce_pkg::MUL_BG; cmd.gsel = bce_pkg::G_LOWMID;
            cmd.acc = bce_pkg::ACC_ADD;
         end
         S_MIX3: begin
            cmd.mul_sel = bce_pkg::MUL_BG; cmd.gsel = bce_pkg::G_BASS;
            cmd.acc = bce_pkg::ACC_ADD;
         end
         S_MIX_FIN:  cmd.op = bce_pkg::OP_MIX_FIN;
         S_OUT:      if (out_free) cmd.op = bce_pkg::OP_OUT;
         default:    ;
      endcase
   end

   // state, stage counters and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         stage_ff      <= '0;
         k_ff          <= bce_pkg::K_UPPER;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // present a finished item, or drop the one just taken
         if (state_ff == S_OUT && out_free) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               stage_ff <= '0;
               k_ff     <= bce_pkg::K_UPPER;
               state_ff <= S_LOAD;
            end
            S_LOAD:     state_ff <= S_BRANCH;
            S_BRANCH:   state_ff <= status.close ? S_AVG_GO : S_XQ_GO;
            S_AVG_GO:   state_ff <= S_AVG_WAIT;
            S_AVG_WAIT: if (status.div_done) state_ff <= S_F_GO;
            S_F_GO:     state_ff <= S_F_WAIT;
            S_F_WAIT:   if (status.div_done) state_ff <= S_NP_MUL;
            S_NP_MUL:   state_ff <= S_NP_SET;
            S_NP_SET:   state_ff <= S_XQ_GO;
            S_XQ_GO:    state_ff <= S_XQ_WAIT;
            S_XQ_WAIT:  if (status.div_done) state_ff <= S_W_UU;
            S_W_UU:     state_ff <= S_W_UX;
            S_W_UX:     state_ff <= S_W_XX;
            S_W_XX:     state_ff <= S_A_OD;
            S_A_OD:     state_ff <= S_A_MC;
            S_A_MC:     state_ff <= S_A_NB;
            S_A_NB:     state_ff <= S_FIN;
            S_FIN: begin
               if (k_ff == bce_pkg::K_LOWER) begin
                  state_ff <= S_MIX0;
               end else begin
                  stage_ff <= stage_ff + 1'b1;
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_LOAD;
               end
            end
            S_MIX0:     state_ff <= S_MIX1;
            S_MIX1:     state_ff <= S_MIX2;
            S_MIX2:     state_ff <= S_MIX3;
            S_MIX3:     state_ff <= S_MIX_FIN;
            S_MIX_FIN: begin
               if (stage_ff == SIDX_W'(STAGES - 1)) begin
                  state_ff <= S_OUT;
               end else begin
                  stage_ff <= stage_ff + 1'b1;
                  k_ff     <= bce_pkg::K_UPPER;
                  state_ff <= S_LOAD;
               end
            end
            S_OUT: if (out_free) begin
               state_ff <= S_IDLE;
            end
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   // divider only reports while a wait state expects it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_AVG_WAIT || state_ff == S_F_WAIT ||
                           state_ff == S_XQ_WAIT))
      else $error("divider done outside a wait state");

   // an accepted item starts the first stage
   a_take_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_LOAD && stage_ff == '0))
      else $error("accepted item did not start at stage zero");

   // a finished result is presented and the block returns to idle
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_tvalid_ff && state_ff == S_IDLE))
      else $error("result not presented");
endmodule
`default_nettype wire

// File: rtl/bce_dp.sv
// Datapath: registers, stage state, shared multiplier, accumulator and divider.
// Uses bce_pkg and bce_div.
`default_nettype none
module bce_dp #(
   parameter int SAMPLE_WIDTH = 24,
   parameter int STAGES       = 9,
   parameter int SIDX_W       = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [bce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bce_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic [SAMPLE_WIDTH-1:0]             in_sample,
   input  wire logic [SIDX_W-1:0]                   stage_idx,
   input  wire bce_pkg::cmd_type                    cmd,
   output bce_pkg::status_type                      status,
   output logic [SAMPLE_WIDTH-1:0]                  out_sample
);
   localparam int VW     = bce_pkg::VW;
   localparam int SUM_W  = bce_pkg::SUM_W;
   localparam int PT_W   = bce_pkg::PT_W;
   localparam int XF     = bce_pkg::XF;
   localparam int W_W    = bce_pkg::W_W;
   localparam int F_W    = bce_pkg::F_W;
   localparam int GAIN_W = bce_pkg::GAIN_W;
   localparam int PER_W  = bce_pkg::PER_W;
   localparam int CNT_W  = bce_pkg::CNT_W;
   localparam int ACC_W  = bce_pkg::ACC_W;
   localparam int AW     = bce_pkg::MUL_AW;
   localparam int BW     = bce_pkg::MUL_BW;
   localparam int PW     = bce_pkg::PROD_W;
   localparam int NW     = bce_pkg::DIV_NW;
   localparam int DW     = bce_pkg::DIV_DW;
   localparam int SW     = SAMPLE_WIDTH;

   localparam logic signed [SUM_W:0] SUM_HI = {2'b00, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W:0] SUM_LO = {2'b11, {(SUM_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] PT_HI = {{(ACC_W-PT_W+1){1'b0}}, {(PT_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] PT_LO = {{(ACC_W-PT_W+1){1'b1}}, {(PT_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] SMP_HI = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SMP_LO = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF_X = ACC_W'(1) <<< (XF - 1);
   localparam logic signed [ACC_W-1:0] HALF_G = ACC_W'(1) <<< 15;
   localparam logic [NW-1:0] Q_PT_MAX = NW'(2147483647);
   localparam logic [NW-1:0] Q_PT_MIN = NW'(64'd2147483648);
   localparam logic [W_W-1:0] ONE_X = W_W'(1) << XF;

   // configuration registers
   logic [GAIN_W-1:0] gain_ff [4];
   logic [PER_W-1:0]  period_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) gain_ff[i] <= bce_pkg::GAIN_RESET;
         period_ff[0] <= bce_pkg::UPPER_RESET;
         period_ff[1] <= bce_pkg::MID_RESET;
         period_ff[2] <= bce_pkg::LOWER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bce_pkg::REG_HIGH_GAIN:     gain_ff[0]   <= csr_wdata[GAIN_W-1:0];
            bce_pkg::REG_HIGHMID_GAIN:  gain_ff[1]   <= csr_wdata[GAIN_W-1:0];
            bce_pkg::REG_LOWMID_GAIN:   gain_ff[2]   <= csr_wdata[GAIN_W-1:0];
            bce_pkg::REG_BASS_GAIN:     gain_ff[3]   <= csr_wdata[GAIN_W-1:0];
            bce_pkg::REG_UPPER_PERIOD:  period_ff[0] <= csr_wdata[PER_W-1:0];
            bce_pkg::REG_MIDDLE_PERIOD: period_ff[1] <= csr_wdata[PER_W-1:0];
            bce_pkg::REG_LOWER_PERIOD:  period_ff[2] <= csr_wdata[PER_W-1:0];
            default: ;
         endcase
      end
   end

   // per-stage state
   logic [PER_W-1:0]        cnt_ff  [STAGES];
   logic signed [SUM_W-1:0] wsum_ff [STAGES];
   logic signed [PT_W-1:0]  newp_ff [STAGES];
   logic signed [PT_W-1:0]  midp_ff [STAGES];
   logic signed [PT_W-1:0]  oldp_ff [STAGES];

   // working registers
   logic signed [VW-1:0]    v_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0]        n_ff;
   logic [PER_W-1:0]        p_ff;
   logic signed [PT_W-1:0]  pn_ff, pm_ff, po_ff, avg_ff;
   logic [F_W-1:0]          f_ff;
   logic [W_W-1:0]          xq_ff, wd_ff, wc_ff, wb_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [VW-1:0]    b_ff [4];
   logic [SW-1:0]           out_ff;

   // period of the current stage, zero taken as one
   logic [PER_W-1:0] per_sel, p_eff;
   always_comb begin
      case (cmd.band)
         bce_pkg::K_UPPER:  per_sel = period_ff[0];
         bce_pkg::K_MIDDLE: per_sel = period_ff[1];
         default:           per_sel = period_ff[2];
      endcase
      p_eff = (per_sel == '0) ? PER_W'(1) : per_sel;
   end

   // window sum with saturation
   logic signed [SUM_W:0]   sum_t;
   logic signed [SUM_W-1:0] sum_sat;
   always_comb begin
      sum_t = {wsum_ff[stage_idx][SUM_W-1], wsum_ff[stage_idx]}
            + {{(SUM_W+1-VW){v_ff[VW-1]}}, v_ff};
      if (sum_t > SUM_HI)      sum_sat = SUM_HI[SUM_W-1:0];
      else if (sum_t < SUM_LO) sum_sat = SUM_LO[SUM_W-1:0];
      else                     sum_sat = sum_t[SUM_W-1:0];
   end

   // divider operands
   logic [SUM_W-1:0]  abs_sum;
   logic [28:0]       f_base;
   logic [NW-1:0]     div_num;
   logic [DW-1:0]     div_den;
   logic [bce_pkg::DIV_LW-1:0] div_len;
   logic              div_done;
   logic [NW-1:0]     div_q;

   always_comb begin
      abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      f_base  = 29'(29'(p_ff) * 29'd500) - 29'd82;
      case (cmd.div_sel)
         bce_pkg::DIV_AVG: begin
            div_num = NW'(abs_sum);
            div_den = DW'(p_ff);
            div_len = bce_pkg::LEN_AVG;
         end
         bce_pkg::DIV_F: begin
            div_num = {f_base, {XF{1'b0}}};
            div_den = DW'(DW'(p_ff) * DW'(1000));
            div_len = bce_pkg::LEN_F;
         end
         default: begin
            div_num = NW'({n_ff, {XF{1'b0}}});
            div_den = DW'({1'b0, p_ff} + 1'b1);
            div_len = bce_pkg::LEN_X;
         end
      endcase
   end

   bce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .len      (div_len),
      .done     (div_done),
      .quotient (div_q)
   );

   // shared multiplier operands
   logic [W_W-1:0]       u_w;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] mul_p;
   always_comb begin
      u_w = ONE_X - xq_ff;
      case (cmd.mul_sel)
         bce_pkg::MUL_AF: begin mul_a = AW'(avg_ff);         mul_b = BW'(f_ff);  end
         bce_pkg::MUL_UU: begin mul_a = AW'(u_w);            mul_b = BW'(u_w);   end
         bce_pkg::MUL_UX: begin mul_a = AW'(u_w);            mul_b = BW'(xq_ff); end
         bce_pkg::MUL_XX: begin mul_a = AW'(xq_ff);          mul_b = BW'(xq_ff); end
         bce_pkg::MUL_OD: begin mul_a = AW'(po_ff);          mul_b = BW'(wd_ff); end
         bce_pkg::MUL_MC: begin mul_a = AW'(pm_ff);          mul_b = BW'(wc_ff); end
         bce_pkg::MUL_NB: begin mul_a = AW'(pn_ff);          mul_b = BW'(wb_ff); end
         bce_pkg::MUL_BG: begin
            mul_a = AW'(b_ff[cmd.gsel]);
            mul_b = BW'(gain_ff[cmd.gsel]);
         end
         default:         begin mul_a = '0;                  mul_b = '0;         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // rounding of curve, newest point and mix
   logic signed [ACC_W-1:0] prod_x, total, np_r, y_r, mix_r;
   logic signed [PT_W-1:0]  np_sat;
   logic signed [VW-1:0]    y_v;
   logic signed [SW-1:0]    mix_sat;
   logic signed [PT_W-1:0]  avg_q;
   logic [W_W-1:0]          xq_q;
   always_comb begin
      prod_x = ACC_W'(prod_ff);
      total  = acc_ff + prod_x;
      np_r   = (prod_x + HALF_X) >>> XF;
      if (np_r > PT_HI)      np_sat = PT_HI[PT_W-1:0];
      else if (np_r < PT_LO) np_sat = PT_LO[PT_W-1:0];
      else                   np_sat = np_r[PT_W-1:0];
      y_r    = ACC_W'(pm_ff) + ((total + HALF_X) >>> XF);
      y_v    = y_r[VW-1:0];
      mix_r  = (total + HALF_G) >>> 16;
      if (mix_r > SMP_HI)      mix_sat = SMP_HI[SW-1:0];
      else if (mix_r < SMP_LO) mix_sat = SMP_LO[SW-1:0];
      else                     mix_sat = mix_r[SW-1:0];
      // signed average from the magnitude quotient
      if (sum_ff[SUM_W-1])
         avg_q = (div_q > Q_PT_MIN) ? PT_LO[PT_W-1:0] : PT_W'(-div_q);
      else
         avg_q = (div_q > Q_PT_MAX) ? PT_HI[PT_W-1:0] : div_q[PT_W-1:0];
      xq_q = (div_q > NW'(ONE_X)) ? ONE_X : div_q[W_W-1:0];
   end

   // stage state update at the end of a stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGES; i++) begin
            cnt_ff[i]  <= '0;
            wsum_ff[i] <= '0;
            newp_ff[i] <= '0;
            midp_ff[i] <= '0;
            oldp_ff[i] <= '0;
         end
      end else if (cmd.op == bce_pkg::OP_FIN) begin
         cnt_ff[stage_idx]  <= n_ff[PER_W-1:0];
         wsum_ff[stage_idx] <= sum_ff;
         newp_ff[stage_idx] <= pn_ff;
         midp_ff[stage_idx] <= pm_ff;
         oldp_ff[stage_idx] <= po_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.mul_sel != bce_pkg::MUL_NONE) prod_ff <= mul_p;

      case (cmd.acc)
         bce_pkg::ACC_LOAD: acc_ff <= prod_x;
         bce_pkg::ACC_ADD:  acc_ff <= acc_ff + prod_x;
         default: ;
      endcase

      case (cmd.lat)
         bce_pkg::LAT_WD: wd_ff <= W_W'(prod_ff >>> XF);
         bce_pkg::LAT_WC: wc_ff <= W_W'(prod_ff >>> (XF - 1));
         bce_pkg::LAT_WB: wb_ff <= W_W'(prod_ff >>> XF);
         default: ;
      endcase

      if (div_done) begin
         case (cmd.div_sel)
            bce_pkg::DIV_AVG: avg_ff <= avg_q;
            bce_pkg::DIV_F:   f_ff   <= div_q[F_W-1:0];
            default:          xq_ff  <= xq_q;
         endcase
      end

      unique case (cmd.op)
         bce_pkg::OP_TAKE: v_ff <= VW'(signed'(in_sample));
         bce_pkg::OP_LOAD: begin
            sum_ff <= sum_sat;
            n_ff   <= CNT_W'(cnt_ff[stage_idx]) + 1'b1;
            p_ff   <= p_eff;
            pn_ff  <= newp_ff[stage_idx];
            pm_ff  <= midp_ff[stage_idx];
            po_ff  <= oldp_ff[stage_idx];
         end
         bce_pkg::OP_NEWPT: begin
            po_ff  <= pm_ff;
            pm_ff  <= pn_ff;
            pn_ff  <= np_sat;
            sum_ff <= '0;
            n_ff   <= '0;
         end
         bce_pkg::OP_FIN: begin
            case (cmd.band)
               bce_pkg::K_UPPER: begin
                  b_ff[0] <= v_ff - y_v;
                  v_ff    <= y_v;
               end
               bce_pkg::K_MIDDLE: begin
                  b_ff[1] <= v_ff - y_v;
                  v_ff    <= y_v;
               end
               default: begin
                  b_ff[2] <= v_ff - y_v;
                  b_ff[3] <= y_v;
               end
            endcase
         end
         bce_pkg::OP_MIX_FIN: v_ff <= VW'(mix_sat);
         bce_pkg::OP_OUT:     out_ff <= v_ff[SW-1:0];
         default: ;
      endcase
   end

   assign status.close    = n_ff > {1'b0, p_ff};
   assign status.div_done = div_done;
   assign out_sample      = out_ff;
endmodule
`default_nettype wire

// File: rtl/bezier_crossover_four_band_eq_unit.sv
// Four-band equalizer from cascaded Bezier crossovers; one sample in, one out.
// Each sample passes all 3*PASSES stages in turn; every stage runs one division, and
// a stage whose window closes on that sample runs two more. A new sample is taken
// only once the last one has gone through all stages into the output register.
// A result waits in the output register while the next item is taken in.
// Synchronous reset clears all stage state and loads the register defaults.
`default_nettype none
module bezier_crossover_four_band_eq_unit #(
   parameter int PASSES       = 3,
   parameter int SAMPLE_WIDTH = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // in_sample
   input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // out_sample
   output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [bce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bce_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int TD_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int STAGES = 3 * PASSES;
   localparam int SIDX_W = $clog2(STAGES);

   bce_pkg::cmd_type    cmd;
   bce_pkg::status_type status;
   logic [SIDX_W-1:0]   stage_idx;
   logic [SAMPLE_WIDTH-1:0] out_sample;

   bce_ctrl #(.STAGES(STAGES), .SIDX_W(SIDX_W)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stage_idx  (stage_idx),
      .cmd        (cmd),
      .status     (status)
   );

   bce_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .STAGES(STAGES), .SIDX_W(SIDX_W)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_sample  (req_tdata[SAMPLE_WIDTH-1:0]),
      .stage_idx  (stage_idx),
      .cmd        (cmd),
      .status     (status),
      .out_sample (out_sample)
   );

   assign rsp_tdata = TD_W'(out_sample);
endmodule
`default_nettype wire

// File: tb/sv/bezier_crossover_four_band_eq_unit_tb.sv
// Self-checking testbench of the four-band Bezier crossover equalizer.
// Depends on bce_pkg and bezier_crossover_four_band_eq_unit from the RTL; drives
// samples and register writes, predicts every output sample and compares it.
`default_nettype none

// Predicts output samples and keeps the ones still owed by the block
class eq_scoreboard;
   localparam int NPASS  = 3;
   localparam int NSTAGE = 3 * NPASS;
   localparam int SW     = 24;
   localparam int XFR    = 24;

   longint gain [4];
   longint period [3];
   longint win_count [NSTAGE];
   longint win_sum [NSTAGE];
   longint pt_new [NSTAGE];
   longint pt_mid [NSTAGE];
   longint pt_old [NSTAGE];
   logic [SW-1:0] owed_q [$];
   int errors;

   function new();
      for (int i = 0; i < 4; i++) gain[i] = bce_pkg::GAIN_RESET;
      period[0] = bce_pkg::UPPER_RESET;
      period[1] = bce_pkg::MID_RESET;
      period[2] = bce_pkg::LOWER_RESET;
      for (int i = 0; i < NSTAGE; i++) begin
         win_count[i] = 0;
         win_sum[i]   = 0;
         pt_new[i]    = 0;
         pt_mid[i]    = 0;
         pt_old[i]    = 0;
      end
      errors = 0;
   endfunction

   function void write_reg(logic [bce_pkg::CSR_IDX_W-1:0] idx, longint v);
      case (idx)
         bce_pkg::REG_HIGH_GAIN:     gain[0] = v & 'h3FFFF;
         bce_pkg::REG_HIGHMID_GAIN:  gain[1] = v & 'h3FFFF;
         bce_pkg::REG_LOWMID_GAIN:   gain[2] = v & 'h3FFFF;
         bce_pkg::REG_BASS_GAIN:     gain[3] = v & 'h3FFFF;
         bce_pkg::REG_UPPER_PERIOD:  period[0] = v & 'hFFFFF;
         bce_pkg::REG_MIDDLE_PERIOD: period[1] = v & 'hFFFFF;
         bce_pkg::REG_LOWER_PERIOD:  period[2] = v & 'hFFFFF;
         default: ;
      endcase
   endfunction

   function longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   // round half up: arithmetic shift floors
   function longint round_down(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   // one crossover stage: window average, then the Bezier point
   function longint crossover(int i, longint x, longint preg);
      longint p, n, sum, avg, f, xq, u, wd, wc, wb, acc, one;
      p   = (preg == 0) ? 1 : preg;
      one = longint'(1) << XFR;
      sum = clamp(win_sum[i] + x, 48);
      n   = win_count[i] + 1;
      if (n > p) begin
         avg = clamp(sum / p, 32);
         f   = ((500 * p - 82) << XFR) / (1000 * p);
         pt_old[i] = pt_mid[i];
         pt_mid[i] = pt_new[i];
         pt_new[i] = clamp(round_down(avg * f, XFR), 32);
         sum = 0;
         n   = 0;
      end
      win_sum[i]   = sum;
      win_count[i] = n;
      xq = (n << XFR) / (p + 1);
      if (xq > one) xq = one;
      u  = one - xq;
      wd = (u * u) >> XFR;
      wc = (2 * u * xq) >> XFR;
      wb = (xq * xq) >> XFR;
      acc = pt_old[i] * wd + pt_mid[i] * wc + pt_new[i] * wb;
      return pt_mid[i] + round_down(acc, XFR);
   endfunction

   function void note_sample(logic [SW-1:0] d);
      longint x, high, hmid, lmid, bass, mix;
      x = longint'(signed'(d));
      for (int ps = 0; ps < NPASS; ps++) begin
         high = x;
         hmid = crossover(3 * ps, high, period[0]);
         high -= hmid;
         lmid = crossover(3 * ps + 1, hmid, period[1]);
         hmid -= lmid;
         bass = crossover(3 * ps + 2, lmid, period[2]);
         lmid -= bass;
         mix = high * gain[0] + hmid * gain[1] + lmid * gain[2] + bass * gain[3];
         x = clamp(round_down(mix, 16), SW);
      end
      owed_q.push_back(x[SW-1:0]);
   endfunction

   task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
   endtask

   task check_sample(logic [SW-1:0] d);
      logic [SW-1:0] exp_d;
      if (owed_q.size() == 0) begin
         report($sformatf("unexpected out_sample %h", d));
      end else begin
         exp_d = owed_q.pop_front();
         if (d !== exp_d)
            report($sformatf("out_sample got %h want %h", d, exp_d));
      end
   endtask
endclass

module bezier_crossover_four_band_eq_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SW  = 24;
   localparam int CDW = bce_pkg::CSR_DATA_W;
   localparam int CIW = bce_pkg::CSR_IDX_W;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [SW-1:0] req_tdata = '0;    // in_sample
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SW-1:0] rsp_tdata;         // out_sample
   logic csr_we = 1'b0;
   logic [CIW-1:0] csr_index = '0;
   logic [CDW-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   eq_scoreboard sb = new();

   bezier_crossover_four_band_eq_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watch both channels; values read here are the ones before this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata);
      end
   end

   task automatic send_sample(logic [SW-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // wait for every owed sample, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CIW-1:0] idx, logic [CDW-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, longint'(v));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all(int g0, int g1, int g2, int g3, int p0, int p1, int p2);
      write_csr(bce_pkg::REG_HIGH_GAIN, CDW'(g0));
      write_csr(bce_pkg::REG_HIGHMID_GAIN, CDW'(g1));
      write_csr(bce_pkg::REG_LOWMID_GAIN, CDW'(g2));
      write_csr(bce_pkg::REG_BASS_GAIN, CDW'(g3));
      write_csr(bce_pkg::REG_UPPER_PERIOD, CDW'(p0));
      write_csr(bce_pkg::REG_MIDDLE_PERIOD, CDW'(p1));
      write_csr(bce_pkg::REG_LOWER_PERIOD, CDW'(p2));
   endtask

   function automatic logic [SW-1:0] rand_sample();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         1: return 24'($signed($urandom_range(64)) - 32);
         2: return '0;
         default: return SW'($urandom);
      endcase
   endfunction

   function automatic int rand_gain();
      case ($urandom_range(5))
         0: return 0;
         1: return 262143;
         default: return $urandom_range(262143);
      endcase
   endfunction

   function automatic int rand_period();
      case ($urandom_range(9))
         0: return 0;
         1: return $urandom_range(100);
         default: return $urandom_range(8, 1);
      endcase
   endfunction

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes and silence with the reset settings
      send_sample(24'h000000);
      send_sample(24'h000000);
      send_sample(24'h7FFFFF);
      send_sample(24'h800000);
      send_sample(24'h7FFFFF);
      send_sample(24'h7FFFFF);
      send_sample(24'hFFFFFF);
      send_sample(24'h000001);
      send_sample(24'h800000);
      send_sample(24'h800000);
      drain();

      // full gains and shortest windows: every pass saturates
      set_all(262143, 262143, 262143, 262143, 1, 1, 1);
      for (int k = 0; k < 5; k++) send_sample(k[0] ? 24'h7FFFFF : 24'h800000);
      drain();

      // zero gains, period zero and a period near the largest
      set_all(0, 0, 0, 0, 0, 999999, 0);
      send_sample(24'h7FFFFF);
      send_sample(24'h123456);
      drain();

      // long window, then the period drops below the count mid-window
      set_all(65536, 131072, 32768, 262143, 2, 3, 20);
      for (int k = 0; k < 6; k++) send_sample(24'h7FFFFF);
      drain();
      write_csr(bce_pkg::REG_LOWER_PERIOD, CDW'(3));
      send_sample(24'h7FFFFF);
      send_sample(24'h400000);
      drain();

      // random phases under each idling pattern
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         set_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
                 rand_period(), rand_period(), rand_period());
         for (int k = 0; k < 90; k++) send_sample(rand_sample());
         drain();
      end

      if (sb.errors == 0 && sb.owed_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #100ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
